### rtl/rotating_xor_checksum_29_31_macros.svh
// ----------------------------------------------------------------------------
// Rotating XOR checksum assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATING_XOR_CHECKSUM_29_31_MACROS_SVH
`define ROTATING_XOR_CHECKSUM_29_31_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define RXC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define RXC_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/rxc_pkg.sv
// ----------------------------------------------------------------------------
// Rotating XOR checksum package
// Types, constants and functions shared by the checksum modules.
// ----------------------------------------------------------------------------
package rxc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned POS_W = 5;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [POS_W-1:0] POS29_MAX = POS_W'(29 - 1);
	localparam logic [POS_W-1:0] POS31_MAX = POS_W'(31 - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BYTE_REVERSE    = 8'd0,
		REG_COMPARE_ENABLED = 8'd1,
		REG_EXPECTED_SUM29  = 8'd2,
		REG_EXPECTED_SUM31  = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic              last_word;
	} in_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] sum_mod29;
		logic [WORD_W-1:0] sum_mod31;
		logic              match;
	} out_word_t;

	typedef struct packed {
		logic              byte_reverse;
		logic              compare_enabled;
		logic [WORD_W-1:0] expected_sum29;
		logic [WORD_W-1:0] expected_sum31;
	} cfg_regs_t;

	typedef struct packed {
		logic fire;
		logic last_word;
	} step_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
		input logic [POS_W-1:0] n);
		logic [2*WORD_W-1:0] d;
		d = {v, v} << n;
		return d[2*WORD_W-1:WORD_W];
	endfunction

	function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

### rtl/rxc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Rotating XOR checksum configuration registers
// Decodes register writes and holds the four configuration registers.
// ----------------------------------------------------------------------------
module rxc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rxc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rxc_pkg::WORD_W-1:0]    cfg_data,
	output rxc_pkg::cfg_regs_t            cfg
);
	import rxc_pkg::*;

	cfg_regs_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_reverse    <= 1'b0;
			cfg_q.compare_enabled <= 1'b1;
			cfg_q.expected_sum29  <= '0;
			cfg_q.expected_sum31  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BYTE_REVERSE: begin
					cfg_q.byte_reverse <= cfg_data[0];
				end
				REG_COMPARE_ENABLED: begin
					cfg_q.compare_enabled <= cfg_data[0];
				end
				REG_EXPECTED_SUM29: begin
					cfg_q.expected_sum29 <= cfg_data;
				end
				REG_EXPECTED_SUM31: begin
					cfg_q.expected_sum31 <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/rxc_in_stage.sv
// ----------------------------------------------------------------------------
// Rotating XOR checksum input stage
// Registers the incoming word and releases it into the accumulators.
// ----------------------------------------------------------------------------
module rxc_in_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  rxc_pkg::in_word_t         in_word,
	input  logic                      out_free,
	output rxc_pkg::step_t            step,
	output logic [rxc_pkg::WORD_W-1:0] data
);
	import rxc_pkg::*;

	logic              valid_s1;
	logic              last_s1;
	logic [WORD_W-1:0] data_s1;
	logic              advance;

	// A last word needs the result register; any other word always moves on.
	assign advance = !last_s1 || out_free;
	assign in_stall = valid_s1 && !advance;

	assign step.fire = valid_s1 && advance;
	assign step.last_word = last_s1;
	assign data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_word.data_word;
			last_s1 <= in_word.last_word;
		end
	end

endmodule

### rtl/rxc_core.sv
// ----------------------------------------------------------------------------
// Rotating XOR checksum core
// Holds both accumulators and position counters and forms the result.
// ----------------------------------------------------------------------------
module rxc_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rxc_pkg::step_t            step,
	input  logic [rxc_pkg::WORD_W-1:0] data,
	input  rxc_pkg::cfg_regs_t        cfg,
	output rxc_pkg::out_word_t        res
);
	import rxc_pkg::*;

	logic [WORD_W-1:0] acc29_q;
	logic [WORD_W-1:0] acc31_q;
	logic [POS_W-1:0]  pos29_q;
	logic [POS_W-1:0]  pos31_q;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] sum29;
	logic [WORD_W-1:0] sum31;

	assign word = cfg.byte_reverse ? swap_bytes(data) : data;
	assign sum29 = acc29_q ^ rotl(word, pos29_q);
	assign sum31 = acc31_q ^ rotl(word, pos31_q);

	assign res.sum_mod29 = sum29;
	assign res.sum_mod31 = sum31;
	assign res.match = !cfg.compare_enabled ||
		(sum29 == cfg.expected_sum29 && sum31 == cfg.expected_sum31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc29_q <= '0;
			acc31_q <= '0;
			pos29_q <= '0;
			pos31_q <= '0;
		end else if (step.fire) begin
			if (step.last_word) begin
				acc29_q <= '0;
				acc31_q <= '0;
				pos29_q <= '0;
				pos31_q <= '0;
			end else begin
				acc29_q <= sum29;
				acc31_q <= sum31;
				pos29_q <= (pos29_q == POS29_MAX) ? '0 : pos29_q + 1'b1;
				pos31_q <= (pos31_q == POS31_MAX) ? '0 : pos31_q + 1'b1;
			end
		end
	end

endmodule

### rtl/rxc_out_stage.sv
// ----------------------------------------------------------------------------
// Rotating XOR checksum result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rxc_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  rxc_pkg::out_word_t res,
	output logic               out_free,
	output logic               out_valid,
	input  logic               out_stall,
	output rxc_pkg::out_word_t out_word
);
	import rxc_pkg::*;

	logic      out_valid_q;
	out_word_t out_word_q;

	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			out_word_q <= res;
		end
	end

endmodule

### rtl/rotating_xor_checksum_29_31.sv
// ----------------------------------------------------------------------------
// Rotating XOR checksum, modulo 29 and modulo 31
// Top level: configuration registers, input stage, core and result register.
// ----------------------------------------------------------------------------
// The block takes one 32-bit word per cycle and folds it, optionally
// byte-reversed, into two XOR sums after rotating it left by position
// counters that run modulo 29 and modulo 31. A last word passes the input
// register into the result register, and words keep streaming in while a
// result waits. Only a last word can stall the input, and only while the
// single result register still holds an earlier result that is stalled.
// Configuration registers are written through the cfg port, which is
// always ready, and must only change while no word is in flight.
module rotating_xor_checksum_29_31 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  rxc_pkg::in_word_t            in_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output rxc_pkg::out_word_t           out_word,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rxc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rxc_pkg::WORD_W-1:0]    cfg_data
);
	import rxc_pkg::*;

	cfg_regs_t         cfg;
	step_t             step;
	logic [WORD_W-1:0] data;
	out_word_t         res;
	logic              out_free;

	rxc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rxc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_free (out_free),
		.step     (step),
		.data     (data)
	);

	rxc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (data),
		.cfg    (cfg),
		.res    (res)
	);

	rxc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step.fire && step.last_word),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

### rtl/rxc_checker.sv
// ----------------------------------------------------------------------------
// Rotating XOR checksum port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "rotating_xor_checksum_29_31_macros.svh"

module rxc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input rxc_pkg::in_word_t            in_word,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         cfg_ready
);
	import rxc_pkg::*;

	// A stalled result must stay offered.
	`RXC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

	// The input only stalls behind a blocked result.
	`RXC_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without cause")

	// A fresh result must trace back to an accepted last word.
	`RXC_ASSERT(a_result_source, $rose(out_valid) |-> $past(in_valid && !in_stall && in_word.last_word, 2), "result without last word")

	// Configuration writes are never refused.
	`RXC_ASSERT_NEVER(a_cfg_ready, !cfg_ready, "configuration port not ready")

endmodule

bind rotating_xor_checksum_29_31 rxc_checker u_rxc_checker (.*);
